// File: rtl/clipped_color_key_sprite_blit_defines.svh
// ----------------------------------------------------------------------------
// Clipped color-key sprite blitter: assertion macros
// Shared property wrappers for the blitter's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef CLIPPED_COLOR_KEY_SPRITE_BLIT_DEFINES_SVH
`define CLIPPED_COLOR_KEY_SPRITE_BLIT_DEFINES_SVH

// same-cycle implication, disabled while reset is held
`define CCKSB_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("blitter check failed: same-cycle property");

// next-cycle implication, disabled while reset is held
`define CCKSB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("blitter check failed: next-cycle property");

`endif

// File: rtl/ccksb_pkg.sv
// ----------------------------------------------------------------------------
// Clipped color-key sprite blitter package
// Screen and sprite size constants, register index codes and size clamp.
// ----------------------------------------------------------------------------
package ccksb_pkg;

  // screen and sprite limits
  localparam int SCREEN_WIDTH    = 320;
  localparam int SCREEN_HEIGHT   = 240;
  localparam int MAX_SPRITE_SIZE = 1024;

  // field and register widths
  localparam int CFG_W   = 11;
  localparam int SIZE_W  = 11;
  localparam int CNT_W   = $clog2(MAX_SPRITE_SIZE);
  localparam int POS_W   = CFG_W + 1;
  localparam int COLOR_W = 8;
  localparam int DX_W    = 9;
  localparam int DY_W    = 8;
  localparam int IDX_W   = 3;

  // configuration register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_SPRITE_X      = 3'd0,
    REG_SPRITE_Y      = 3'd1,
    REG_SPRITE_WIDTH  = 3'd2,
    REG_SPRITE_HEIGHT = 3'd3,
    REG_KEY_ENABLE    = 3'd4,
    REG_KEY_COLOR     = 3'd5
  } cfg_reg_t;

  // clamp a sprite dimension to 1 .. MAX_SPRITE_SIZE
  function automatic logic [SIZE_W-1:0] size_limit(input logic [SIZE_W-1:0] v);
    logic [SIZE_W-1:0] res;
    if (v == '0) begin
      res = SIZE_W'(1);
    end else if (v > SIZE_W'(MAX_SPRITE_SIZE)) begin
      res = SIZE_W'(MAX_SPRITE_SIZE);
    end else begin
      res = v;
    end
    return res;
  endfunction

endpackage

// File: rtl/clipped_color_key_sprite_blit.sv
// ----------------------------------------------------------------------------
// Clipped color-key sprite blitter
// Places raster-order sprite pixels on a 320x240 screen, drops pixels that
// fall off screen or match the color key, and emits framebuffer writes.
// ----------------------------------------------------------------------------
//  channel   direction   handshake          payload
//  in        input       in_valid/in_stall  in_source_color
//  out       output      out_valid/out_stall out_dest_x, out_dest_y, out_dest_color
//  cfg       input       cfg_we             cfg_index, cfg_wdata
//
//  one pixel per clock while in_stall is low; each write passes through the
//  position register, then the result register
//  rst_n is synchronous: counters clear, registers return to their defaults
//  a stalled output holds its word; the position stage still takes one more
//  pixel, then in_stall rises until the output drains
//  a configuration write to a mapped index resets the column and row counters
// ----------------------------------------------------------------------------
`include "clipped_color_key_sprite_blit_defines.svh"

module clipped_color_key_sprite_blit (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration
  input  logic                          cfg_we,
  input  logic [ccksb_pkg::IDX_W-1:0]   cfg_index,
  input  logic [ccksb_pkg::CFG_W-1:0]   cfg_wdata,
  // source pixels
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [ccksb_pkg::COLOR_W-1:0] in_source_color,
  // framebuffer writes
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [ccksb_pkg::DX_W-1:0]    out_dest_x,
  output logic [ccksb_pkg::DY_W-1:0]    out_dest_y,
  output logic [ccksb_pkg::COLOR_W-1:0] out_dest_color
);

  // configuration registers
  logic [ccksb_pkg::CFG_W-1:0]   sprite_x_r;
  logic [ccksb_pkg::CFG_W-1:0]   sprite_y_r;
  logic [ccksb_pkg::SIZE_W-1:0]  sprite_w_r;
  logic [ccksb_pkg::SIZE_W-1:0]  sprite_h_r;
  logic                          key_en_r;
  logic [ccksb_pkg::COLOR_W-1:0] key_color_r;
  logic                          cfg_hit;

  // sprite counters
  logic [ccksb_pkg::CNT_W-1:0]   col_r, col_nxt;
  logic [ccksb_pkg::CNT_W-1:0]   row_r, row_nxt;
  logic [ccksb_pkg::SIZE_W-1:0]  w_lim, h_lim;
  logic                          col_last, row_last;

  // position stage
  logic                          s1_valid_r;
  logic [ccksb_pkg::POS_W-1:0]   s1_px_r, s1_py_r;
  logic [ccksb_pkg::COLOR_W-1:0] s1_color_r;
  logic [ccksb_pkg::POS_W-1:0]   px_nxt, py_nxt;

  // result stage
  logic                          out_valid_r;
  logic [ccksb_pkg::DX_W-1:0]    out_x_r;
  logic [ccksb_pkg::DY_W-1:0]    out_y_r;
  logic [ccksb_pkg::COLOR_W-1:0] out_color_r;

  logic in_accept, s2_ready, s1_advance, on_screen, keyed;

  // handshake
  assign s2_ready   = !out_valid_r || !out_stall;
  assign s1_advance = s1_valid_r && s2_ready;
  assign in_stall   = s1_valid_r && !s2_ready;
  assign in_accept  = in_valid && !in_stall;

  // register decode
  always_comb begin
    unique case (cfg_index) inside
      ccksb_pkg::REG_SPRITE_X,
      ccksb_pkg::REG_SPRITE_Y,
      ccksb_pkg::REG_SPRITE_WIDTH,
      ccksb_pkg::REG_SPRITE_HEIGHT,
      ccksb_pkg::REG_KEY_ENABLE,
      ccksb_pkg::REG_KEY_COLOR: cfg_hit = cfg_we;
      default:                  cfg_hit = 1'b0;
    endcase
  end

  // configuration write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sprite_x_r  <= '0;
      sprite_y_r  <= '0;
      sprite_w_r  <= ccksb_pkg::SIZE_W'(8);
      sprite_h_r  <= ccksb_pkg::SIZE_W'(8);
      key_en_r    <= 1'b0;
      key_color_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ccksb_pkg::REG_SPRITE_X:      sprite_x_r  <= cfg_wdata;
        ccksb_pkg::REG_SPRITE_Y:      sprite_y_r  <= cfg_wdata;
        ccksb_pkg::REG_SPRITE_WIDTH:  sprite_w_r  <= cfg_wdata;
        ccksb_pkg::REG_SPRITE_HEIGHT: sprite_h_r  <= cfg_wdata;
        ccksb_pkg::REG_KEY_ENABLE:    key_en_r    <= cfg_wdata[0];
        ccksb_pkg::REG_KEY_COLOR:     key_color_r <= cfg_wdata[ccksb_pkg::COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  // counter wrap at the clamped sprite size
  assign w_lim    = ccksb_pkg::size_limit(sprite_w_r);
  assign h_lim    = ccksb_pkg::size_limit(sprite_h_r);
  assign col_last = (ccksb_pkg::SIZE_W'(col_r) + ccksb_pkg::SIZE_W'(1)) >= w_lim;
  assign row_last = (ccksb_pkg::SIZE_W'(row_r) + ccksb_pkg::SIZE_W'(1)) >= h_lim;

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (cfg_hit) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (in_accept) begin
      if (col_last) begin
        col_nxt = '0;
        row_nxt = row_last ? '0 : row_r + ccksb_pkg::CNT_W'(1);
      end else begin
        col_nxt = col_r + ccksb_pkg::CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // screen position: sign-extended origin plus offset
  assign px_nxt = {sprite_x_r[ccksb_pkg::CFG_W-1], sprite_x_r} + ccksb_pkg::POS_W'(col_r);
  assign py_nxt = {sprite_y_r[ccksb_pkg::CFG_W-1], sprite_y_r} + ccksb_pkg::POS_W'(row_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_px_r    <= px_nxt;
      s1_py_r    <= py_nxt;
      s1_color_r <= in_source_color;
    end
  end

  // clip and key test
  assign on_screen = !s1_px_r[ccksb_pkg::POS_W-1] && !s1_py_r[ccksb_pkg::POS_W-1]
                  && (s1_px_r < ccksb_pkg::POS_W'(ccksb_pkg::SCREEN_WIDTH))
                  && (s1_py_r < ccksb_pkg::POS_W'(ccksb_pkg::SCREEN_HEIGHT));
  assign keyed     = key_en_r && (s1_color_r == key_color_r);

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_ready) begin
      out_valid_r <= s1_valid_r && on_screen && !keyed;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready) begin
      out_x_r     <= s1_px_r[ccksb_pkg::DX_W-1:0];
      out_y_r     <= s1_py_r[ccksb_pkg::DY_W-1:0];
      out_color_r <= s1_color_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_dest_x     = out_x_r;
  assign out_dest_y     = out_y_r;
  assign out_dest_color = out_color_r;

  // checks
  `CCKSB_ASSERT_NOW(a_col_in_range, clk, rst_n, 1'b1, ccksb_pkg::SIZE_W'(col_r) < w_lim)
  `CCKSB_ASSERT_NOW(a_row_in_range, clk, rst_n, 1'b1, ccksb_pkg::SIZE_W'(row_r) < h_lim)
  `CCKSB_ASSERT_NOW(a_out_on_screen, clk, rst_n, out_valid_r,
    (ccksb_pkg::POS_W'(out_x_r) < ccksb_pkg::POS_W'(ccksb_pkg::SCREEN_WIDTH)) &&
    (ccksb_pkg::POS_W'(out_y_r) < ccksb_pkg::POS_W'(ccksb_pkg::SCREEN_HEIGHT)))
  `CCKSB_ASSERT_NEXT(a_cfg_restarts, clk, rst_n, cfg_hit, (col_r == '0) && (row_r == '0))

endmodule

// File: tb/sv/clipped_color_key_sprite_blit_tb.sv
// ----------------------------------------------------------------------------
// Clipped color-key sprite blitter testbench
// Streams pixel words through the blitter under random idling, long output
// holds and drain pauses, predicts every framebuffer write from a raster
// position tracker and checks each output word in order.
// ----------------------------------------------------------------------------
module clipped_color_key_sprite_blit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // indexes past the register list, writes there must be ignored
  localparam logic [ccksb_pkg::IDX_W-1:0] REG_UNMAPPED_LO = 3'd6;
  localparam logic [ccksb_pkg::IDX_W-1:0] REG_UNMAPPED_HI = 3'd7;

  localparam int SETTLE_CYCLES = 6;
  localparam int DRAIN_CYCLES  = 8;
  localparam int HOLD_CYCLES   = 300;
  localparam int TIMEOUT_NS    = 4_000_000;

  typedef struct packed {
    logic [ccksb_pkg::DX_W-1:0]    x;
    logic [ccksb_pkg::DY_W-1:0]    y;
    logic [ccksb_pkg::COLOR_W-1:0] color;
  } fb_write_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          cfg_we = 1'b0;
  logic [ccksb_pkg::IDX_W-1:0]   cfg_index = '0;
  logic [ccksb_pkg::CFG_W-1:0]   cfg_wdata = '0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic [ccksb_pkg::COLOR_W-1:0] in_source_color = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [ccksb_pkg::DX_W-1:0]    out_dest_x;
  logic [ccksb_pkg::DY_W-1:0]    out_dest_y;
  logic [ccksb_pkg::COLOR_W-1:0] out_dest_color;

  // shadow of the sprite registers and raster position
  logic [ccksb_pkg::CFG_W-1:0]   spr_x = '0;
  logic [ccksb_pkg::CFG_W-1:0]   spr_y = '0;
  logic [ccksb_pkg::CFG_W-1:0]   spr_width = ccksb_pkg::CFG_W'(8);
  logic [ccksb_pkg::CFG_W-1:0]   spr_height = ccksb_pkg::CFG_W'(8);
  logic                          key_on = 1'b0;
  logic [ccksb_pkg::COLOR_W-1:0] key_value = '0;
  int                            col_pos = 0;
  int                            row_pos = 0;

  fb_write_t pending_writes[$];
  int        fail_count = 0;
  int        src_idle_pct = 0;
  int        dst_idle_pct = 0;
  int        hold_req = 0;
  int        hold_left = 0;

  clipped_color_key_sprite_blit u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_source_color (in_source_color),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_dest_x      (out_dest_x),
    .out_dest_y      (out_dest_y),
    .out_dest_color  (out_dest_color)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // run limit
  initial begin
    #(TIMEOUT_NS);
    $display("clipped_color_key_sprite_blit_tb: errors");
    $finish;
  end

  task automatic log_fail(input string what);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%s", what);
    end
  endtask

  // sprite dimension as the blitter uses it
  function automatic int clamp_dim(input logic [ccksb_pkg::CFG_W-1:0] v);
    if (v == '0) begin
      return 1;
    end
    if (v > ccksb_pkg::MAX_SPRITE_SIZE) begin
      return ccksb_pkg::MAX_SPRITE_SIZE;
    end
    return int'(v);
  endfunction

  // expected framebuffer write for one taken pixel, then advance the raster
  task automatic place_pixel(input logic [ccksb_pkg::COLOR_W-1:0] color);
    int        span_w;
    int        span_h;
    int        px;
    int        py;
    fb_write_t wr;
    span_w = clamp_dim(spr_width);
    span_h = clamp_dim(spr_height);
    px = int'($signed(spr_x)) + col_pos;
    py = int'($signed(spr_y)) + row_pos;
    if (px >= 0 && px < ccksb_pkg::SCREEN_WIDTH &&
        py >= 0 && py < ccksb_pkg::SCREEN_HEIGHT &&
        !(key_on && color == key_value)) begin
      wr.x     = ccksb_pkg::DX_W'(px);
      wr.y     = ccksb_pkg::DY_W'(py);
      wr.color = color;
      pending_writes.push_back(wr);
    end
    if (col_pos + 1 >= span_w) begin
      col_pos = 0;
      row_pos = (row_pos + 1 >= span_h) ? 0 : row_pos + 1;
    end else begin
      col_pos++;
    end
  endtask

  // offer one pixel word, with random idle cycles ahead of it
  task automatic send_pixel(input logic [ccksb_pkg::COLOR_W-1:0] color);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_source_color <= color;
    do @(posedge clk); while (in_stall !== 1'b0);
    place_pixel(color);
  endtask

  // stop offering until every predicted write has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_writes.size() != 0);
  endtask

  // drained, plus time for clipped pixels still in the pipe
  task automatic settle();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [ccksb_pkg::IDX_W-1:0] idx,
                           input logic [ccksb_pkg::CFG_W-1:0] val);
    bit mapped;
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    mapped = 1'b1;
    case (idx)
      ccksb_pkg::REG_SPRITE_X:      spr_x = val;
      ccksb_pkg::REG_SPRITE_Y:      spr_y = val;
      ccksb_pkg::REG_SPRITE_WIDTH:  spr_width = val;
      ccksb_pkg::REG_SPRITE_HEIGHT: spr_height = val;
      ccksb_pkg::REG_KEY_ENABLE:    key_on = val[0];
      ccksb_pkg::REG_KEY_COLOR:     key_value = val[ccksb_pkg::COLOR_W-1:0];
      default:                      mapped = 1'b0;
    endcase
    // any listed register restarts the raster
    if (mapped) begin
      col_pos = 0;
      row_pos = 0;
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_sprite(input logic [ccksb_pkg::CFG_W-1:0] xv,
                             input logic [ccksb_pkg::CFG_W-1:0] yv,
                             input logic [ccksb_pkg::CFG_W-1:0] wv,
                             input logic [ccksb_pkg::CFG_W-1:0] hv,
                             input logic [ccksb_pkg::CFG_W-1:0] ken,
                             input logic [ccksb_pkg::CFG_W-1:0] kc);
    settle();
    write_reg(ccksb_pkg::REG_SPRITE_X, xv);
    write_reg(ccksb_pkg::REG_SPRITE_Y, yv);
    write_reg(ccksb_pkg::REG_SPRITE_WIDTH, wv);
    write_reg(ccksb_pkg::REG_SPRITE_HEIGHT, hv);
    write_reg(ccksb_pkg::REG_KEY_ENABLE, ken);
    write_reg(ccksb_pkg::REG_KEY_COLOR, kc);
  endtask

  // mostly small sizes, sometimes zero, the maximum or past the maximum
  function automatic logic [ccksb_pkg::CFG_W-1:0] pick_dim(input int typical);
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return ccksb_pkg::CFG_W'($urandom_range(ccksb_pkg::MAX_SPRITE_SIZE + 1,
                                                       (1 << ccksb_pkg::CFG_W) - 1));
      2:       return ccksb_pkg::CFG_W'(ccksb_pkg::MAX_SPRITE_SIZE);
      default: return ccksb_pkg::CFG_W'($urandom_range(1, typical));
    endcase
  endfunction

  // output stall: long hold when asked, otherwise random
  always @(posedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(0, 99) < dst_idle_pct);
    end
  end

  // compare each output word with the oldest predicted write
  always @(posedge clk) begin
    fb_write_t due;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_writes.size() == 0) begin
        log_fail($sformatf("unexpected write x=%0d y=%0d color=%02h",
                           out_dest_x, out_dest_y, out_dest_color));
      end else begin
        due = pending_writes.pop_front();
        if (out_dest_x !== due.x || out_dest_y !== due.y ||
            out_dest_color !== due.color) begin
          log_fail($sformatf({"mismatch: expected x=%0d y=%0d color=%02h, ",
                              "got x=%0d y=%0d color=%02h"},
                             due.x, due.y, due.color, out_dest_x, out_dest_y, out_dest_color));
        end
      end
    end
  end

  // 8x8 sprite at the origin straight out of reset, row wrap included
  task automatic test_reset_defaults();
    send_pixel(8'h00);
    send_pixel(8'hFF);
    send_pixel(8'h55);
    send_pixel(8'hAA);
    send_pixel(8'h01);
    send_pixel(8'h80);
    send_pixel(8'h7F);
    send_pixel(8'hFE);
    send_pixel(8'h0F);
    send_pixel(8'hF0);
  endtask

  // bottom-right corner clip, key hit and miss, zero height
  task automatic test_key_and_clip();
    load_sprite(ccksb_pkg::CFG_W'(318), ccksb_pkg::CFG_W'(238), ccksb_pkg::CFG_W'(3), '0,
                11'h7FF, 11'h7FF);
    send_pixel(8'hFF);
    send_pixel(8'h00);
    send_pixel(8'h12);
    send_pixel(8'h34);
  endtask

  // position extremes, oversize width, ignored index, restart on write
  task automatic test_extremes_and_restart();
    load_sprite(11'h400, 11'h3FF, ccksb_pkg::CFG_W'(8), ccksb_pkg::CFG_W'(8), '0, '0);
    send_pixel(8'hC3);
    send_pixel(8'h3C);
    load_sprite(11'h3FF, 11'h400, ccksb_pkg::CFG_W'(8), ccksb_pkg::CFG_W'(8), '0, '0);
    send_pixel(8'h5A);
    send_pixel(8'hA5);
    load_sprite(ccksb_pkg::CFG_W'(-2), '0, 11'h7FF, ccksb_pkg::CFG_W'(1),
                ccksb_pkg::CFG_W'(1), ccksb_pkg::CFG_W'(8'hFF));
    send_pixel(8'h00);
    send_pixel(8'h01);
    settle();
    write_reg(REG_UNMAPPED_HI, 11'h7FF);
    send_pixel(8'h80);
    send_pixel(8'h7F);
    settle();
    write_reg(ccksb_pkg::REG_KEY_ENABLE, 11'h7FE);
    send_pixel(8'hFF);
    send_pixel(8'hFF);
    send_pixel(8'hFF);
  endtask

  // random sprites around the screen edges with random keying
  task automatic test_random_sprites(input int n_pixels);
    int                          sent;
    int                          n;
    int                          pos;
    logic [ccksb_pkg::CFG_W-1:0] xv;
    logic [ccksb_pkg::CFG_W-1:0] yv;
    logic [ccksb_pkg::CFG_W-1:0] wv;
    logic [ccksb_pkg::CFG_W-1:0] hv;
    logic [ccksb_pkg::CFG_W-1:0] kev;
    logic [ccksb_pkg::CFG_W-1:0] kcv;
    sent = 0;
    while (sent < n_pixels) begin
      pos = $urandom_range(0, 380) - 40;
      xv  = ($urandom_range(0, 4) == 0) ? ccksb_pkg::CFG_W'($urandom) : ccksb_pkg::CFG_W'(pos);
      pos = $urandom_range(0, 300) - 40;
      yv  = ($urandom_range(0, 4) == 0) ? ccksb_pkg::CFG_W'($urandom) : ccksb_pkg::CFG_W'(pos);
      wv  = pick_dim(24);
      hv  = pick_dim(12);
      kev = ccksb_pkg::CFG_W'($urandom);
      kcv = ccksb_pkg::CFG_W'($urandom);
      load_sprite(xv, yv, wv, hv, kev, kcv);
      n = clamp_dim(wv) * clamp_dim(hv);
      n = n + $urandom_range(0, n);
      if (n > 48) begin
        n = 48;
      end
      for (int i = 0; i < n; i++) begin
        // halfway through: maybe pause for a full drain, maybe poke a dead index
        if (i == n / 2) begin
          case ($urandom_range(0, 5))
            0: wait_drained();
            1: begin
              settle();
              write_reg($urandom_range(0, 1) ? REG_UNMAPPED_LO : REG_UNMAPPED_HI,
                        ccksb_pkg::CFG_W'($urandom));
            end
            default: ;
          endcase
        end
        send_pixel(($urandom_range(0, 3) == 0) ? key_value : ccksb_pkg::COLOR_W'($urandom));
      end
      sent += n;
    end
  endtask

  // output held for a long stretch while pixels keep coming
  task automatic test_output_hold();
    load_sprite(ccksb_pkg::CFG_W'(20), ccksb_pkg::CFG_W'(30), ccksb_pkg::CFG_W'(16),
                ccksb_pkg::CFG_W'(4), '0, '0);
    hold_req = HOLD_CYCLES;
    repeat (40) send_pixel(ccksb_pkg::COLOR_W'($urandom));
    wait_drained();
    repeat (20) send_pixel(ccksb_pkg::COLOR_W'($urandom));
  endtask

  // one full row of a maximum-width sprite, visible only at its right end
  task automatic test_wide_row_wrap();
    load_sprite(ccksb_pkg::CFG_W'(-1010), ccksb_pkg::CFG_W'(100), 11'h7FF,
                ccksb_pkg::CFG_W'(ccksb_pkg::MAX_SPRITE_SIZE + 1), '0, '0);
    repeat (ccksb_pkg::MAX_SPRITE_SIZE + 20) send_pixel(ccksb_pkg::COLOR_W'($urandom));
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // sender idles lightly, receiver heavily
    src_idle_pct = 19;
    dst_idle_pct = 55;
    test_reset_defaults();
    test_key_and_clip();
    test_extremes_and_restart();
    test_random_sprites(100);
    test_output_hold();

    // sender idles heavily, receiver lightly
    src_idle_pct = 55;
    dst_idle_pct = 19;
    test_random_sprites(100);

    // full rate both ways
    src_idle_pct = 0;
    dst_idle_pct = 0;
    test_wide_row_wrap();
    test_random_sprites(100);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_writes.size() == 0) begin
      $display("clipped_color_key_sprite_blit_tb: clean");
    end else begin
      $display("clipped_color_key_sprite_blit_tb: errors");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/ccksb_pkg.sv
rtl/clipped_color_key_sprite_blit.sv
tb/sv/clipped_color_key_sprite_blit_tb.sv
